>>> design/msct_pkg.sv
package msct_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int COORD_W       = 32;
   localparam int RADIUS_W      = 31;
   localparam int REQ_DATA_W    = 224;
   localparam int RSP_DATA_W    = 224;

   // Step counts of the iterative phases.
   localparam int MUL_STEPS  = 11;
   localparam int WIDE_STEPS = 64;
   localparam int SQRT_STEPS = 64;
   localparam int DIV_STEPS  = 64 + FRACTION_BITS;
   localparam int MOVE_STEPS = 7;
   localparam int STEP_W     = 7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_NORM, ST_MUL, ST_PREP, ST_WINIT, ST_WIDE,
      ST_JFORM, ST_SQRT, ST_RANGE, ST_DIV, ST_TSAT, ST_MOVE, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_DIFF, OP_NORM, OP_MUL, OP_PREP, OP_WINIT, OP_WIDE,
      OP_JFORM, OP_SQRT, OP_RANGE, OP_DIV, OP_TSAT, OP_MOVE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STEP_W-1:0]   step;
      logic                capture;
      logic                out_load;
      logic                out_hit;
   } cmd_type;

   typedef struct packed {
      logic p_zero;
      logic j_neg;
      logic range_miss;
   } status_type;

endpackage

>>> design/moving_sphere_collision_time.sv
// A hit result runs through every phase. A miss ends sooner: on negligible motion
// after the products, on a negative discriminant after the wide products, or when
// no root lies in the frame after the square root. A sphere A request is stored.
// Tests do not overlap; a result waits for a free output. The bit-serial loops:
// 64-bit products (64 steps), square root (64), time divider (64 + FRACTION_BITS).
// Reset (synchronous) clears the controller and the held sphere A to zero.
module moving_sphere_collision_time
   import msct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // radius, start_x, start_y, start_z, end_x, end_y, end_z, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // slot
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // contact_time, a_contact_x/y/z, b_contact_x/y/z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   msct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   msct_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> design/msct_ctrl.sv
module msct_ctrl
   import msct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output cmd_type    cmd,
   input  status_type status
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_tvalid && req_tuser) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:  state_in = ST_NORM;
         ST_NORM: begin
            state_in = ST_MUL;
            step_in  = '0;
         end
         ST_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               state_in = ST_PREP;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PREP: begin
            if (status.p_zero) begin
               state_in = ST_FINISH;
               hit_in   = 1'b0;
            end else begin
               state_in = ST_WINIT;
            end
         end
         ST_WINIT: begin
            state_in = ST_WIDE;
            step_in  = '0;
         end
         ST_WIDE: begin
            if (step_ff == STEP_W'(WIDE_STEPS - 1)) begin
               state_in = ST_JFORM;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_JFORM: begin
            step_in = '0;
            if (status.j_neg) begin
               state_in = ST_FINISH;
               hit_in   = 1'b0;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_RANGE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RANGE: begin
            step_in = '0;
            if (status.range_miss) begin
               state_in = ST_FINISH;
               hit_in   = 1'b0;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_TSAT;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_TSAT: begin
            state_in = ST_MOVE;
            step_in  = '0;
         end
         ST_MOVE: begin
            if (step_ff == STEP_W'(MOVE_STEPS - 1)) begin
               state_in = ST_FINISH;
               step_in  = '0;
               hit_in   = 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.out_load = (state_ff == ST_FINISH) && out_free;
      cmd.out_hit  = hit_ff;
      unique case (state_ff)
         ST_DIFF:  cmd.op = OP_DIFF;
         ST_NORM:  cmd.op = OP_NORM;
         ST_MUL:   cmd.op = OP_MUL;
         ST_PREP:  cmd.op = OP_PREP;
         ST_WINIT: cmd.op = OP_WINIT;
         ST_WIDE:  cmd.op = OP_WIDE;
         ST_JFORM: cmd.op = OP_JFORM;
         ST_SQRT:  cmd.op = OP_SQRT;
         ST_RANGE: cmd.op = OP_RANGE;
         ST_DIV:   cmd.op = OP_DIV;
         ST_TSAT:  cmd.op = OP_TSAT;
         ST_MOVE:  cmd.op = OP_MOVE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while a test is running");

   a_start_test: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (state_ff == ST_DIFF))
      else $error("second sphere did not start the test");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_W'(DIV_STEPS)))
      else $error("divider step out of range");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished result not presented");

endmodule

>>> design/msct_dp.sv
module msct_dp
   import msct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   // Particle A (held) and particle B.
   logic [RADIUS_W-1:0]       held_rad_ff, b_rad_ff;
   logic signed [COORD_W-1:0] held_st_ff [3];
   logic signed [COORD_W-1:0] held_en_ff [3];
   logic signed [COORD_W-1:0] b_st_ff [3];
   logic signed [COORD_W-1:0] b_en_ff [3];

   logic signed [32:0] c0_ff [3];
   logic signed [33:0] d_ff [3];
   logic [31:0]        r_ff;

   logic [29:0] cm_ff [3];
   logic [29:0] dm_ff [3];
   logic        cs_ff [3];
   logic        ds_ff [3];
   logic [29:0] rm_ff;

   logic signed [63:0] p_ff, q_ff, rr_ff, r2_ff, diff_ff;

   logic [32:0]  mul_a;
   logic [31:0]  mul_b;
   logic         mul_neg;
   logic [64:0]  prod_ff;
   logic         prod_neg_ff;
   logic signed [63:0] prod_s;

   logic [127:0] qa_ff, ta_ff, q2_ff, tt_ff;
   logic [63:0]  qb_ff, tb_ff;

   logic [127:0] jsh_ff;
   logic [66:0]  rem_ff;
   logic [63:0]  root_ff;

   logic [63:0]  num_ff, drem_ff;
   logic [32:0]  quo_ff;
   logic         big_ff, nneg_ff;

   logic signed [COORD_W-1:0] t_ff;
   logic signed [COORD_W-1:0] res_ff [6];

   logic                      hit_out_ff;
   logic signed [COORD_W-1:0] time_out_ff;
   logic signed [COORD_W-1:0] pos_out_ff [6];

   // Unpacked request.
   logic [RADIUS_W-1:0]       in_rad;
   logic signed [COORD_W-1:0] in_st [3];
   logic signed [COORD_W-1:0] in_en [3];

   assign in_rad = req_tdata[RADIUS_W-1:0];
   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign in_st[i] = req_tdata[RADIUS_W + COORD_W*i +: COORD_W];
      assign in_en[i] = req_tdata[RADIUS_W + COORD_W*(3+i) +: COORD_W];
   end

   // Normalization: find the shift that brings every magnitude below 2^30.
   logic [32:0] c0_mag [3];
   logic [33:0] d_mag [3];
   logic [33:0] or_mag;
   logic [2:0]  norm_k;

   always_comb begin
      or_mag = {2'b0, r_ff};
      for (int i = 0; i < 3; i++) begin
         c0_mag[i] = c0_ff[i][32] ? 33'(-c0_ff[i]) : 33'(c0_ff[i]);
         d_mag[i]  = d_ff[i][33] ? 34'(-d_ff[i]) : 34'(d_ff[i]);
         or_mag    = or_mag | {1'b0, c0_mag[i]} | d_mag[i];
      end
      priority if (or_mag[33]) norm_k = 3'd4;
      else if (or_mag[32])     norm_k = 3'd3;
      else if (or_mag[31])     norm_k = 3'd2;
      else if (or_mag[30])     norm_k = 3'd1;
      else                     norm_k = 3'd0;
   end

   // Motion of each centre over the frame: A axes first, then B.
   logic signed [32:0] delta [6];
   logic signed [COORD_W-1:0] start6 [6];
   for (genvar i = 0; i < 3; i++) begin : g_delta
      assign delta[i]    = 33'(held_en_ff[i]) - 33'(held_st_ff[i]);
      assign delta[i+3]  = 33'(b_en_ff[i]) - 33'(b_st_ff[i]);
      assign start6[i]   = held_st_ff[i];
      assign start6[i+3] = b_st_ff[i];
   end

   logic [2:0]  mv_idx, mv_prev;
   logic [31:0] t_mag;
   assign mv_idx  = cmd.step[2:0];
   assign mv_prev = cmd.step[2:0] - 3'd1;
   assign t_mag   = t_ff[31] ? 32'(-33'(t_ff)) : 32'(t_ff);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      if (cmd.op == OP_MUL) begin
         unique case (cmd.step)
            7'd0: begin mul_a = 33'(dm_ff[0]); mul_b = 32'(dm_ff[0]); end
            7'd1: begin mul_a = 33'(dm_ff[1]); mul_b = 32'(dm_ff[1]); end
            7'd2: begin mul_a = 33'(dm_ff[2]); mul_b = 32'(dm_ff[2]); end
            7'd3: begin
               mul_a = 33'(cm_ff[0]); mul_b = 32'(dm_ff[0]); mul_neg = cs_ff[0] ^ ds_ff[0];
            end
            7'd4: begin
               mul_a = 33'(cm_ff[1]); mul_b = 32'(dm_ff[1]); mul_neg = cs_ff[1] ^ ds_ff[1];
            end
            7'd5: begin
               mul_a = 33'(cm_ff[2]); mul_b = 32'(dm_ff[2]); mul_neg = cs_ff[2] ^ ds_ff[2];
            end
            7'd6: begin mul_a = 33'(cm_ff[0]); mul_b = 32'(cm_ff[0]); end
            7'd7: begin mul_a = 33'(cm_ff[1]); mul_b = 32'(cm_ff[1]); end
            7'd8: begin mul_a = 33'(cm_ff[2]); mul_b = 32'(cm_ff[2]); end
            7'd9: begin mul_a = 33'(rm_ff);    mul_b = 32'(rm_ff); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (cmd.op == OP_MOVE && mv_idx < 3'd6) begin
         mul_a   = delta[mv_idx][32] ? 33'(-delta[mv_idx]) : 33'(delta[mv_idx]);
         mul_b   = t_mag;
         mul_neg = delta[mv_idx][32] ^ t_ff[31];
      end
   end

   assign prod_s = prod_neg_ff ? -$signed(prod_ff[63:0]) : $signed(prod_ff[63:0]);

   // Discriminant, square root step, range test, divider step, time.
   logic [127:0] j_val;
   logic         diff_le0;
   logic [66:0]  sq_remx, sq_trial;
   logic signed [65:0] q_x, n_plus, n_minus, p_x;
   logic         in_plus, in_minus;
   logic [65:0]  nm_mag;
   logic [64:0]  dv_x, dv_den;
   logic         dv_ge;
   logic signed [COORD_W-1:0] t_sat;

   // Centre update for the product that finished last cycle.
   logic [64:0]        mv_sh;
   logic signed [66:0] mv_off, mv_sum;
   logic signed [COORD_W-1:0] mv_res;

   always_comb begin
      diff_le0 = diff_ff[63] || (diff_ff == '0);
      j_val    = diff_le0 ? (q2_ff + tt_ff) : (q2_ff - tt_ff);
      status.p_zero     = (p_ff == '0);
      status.j_neg      = !diff_le0 && (q2_ff < tt_ff);

      sq_remx  = {rem_ff[64:0], jsh_ff[127:126]};
      sq_trial = {1'b0, root_ff, 2'b01};

      q_x      = 66'(q_ff);
      p_x      = 66'(p_ff);
      n_plus   = -q_x + $signed({2'b00, root_ff});
      n_minus  = -q_x - $signed({2'b00, root_ff});
      in_plus  = !n_plus[65] && (n_plus <= p_x);
      in_minus = !n_minus[65] && (n_minus <= p_x);
      status.range_miss = !in_plus && !in_minus;
      nm_mag   = n_minus[65] ? 66'(-n_minus) : 66'(n_minus);

      dv_x   = {drem_ff, num_ff[63]};
      dv_den = {1'b0, p_ff};
      dv_ge  = (dv_x >= dv_den);

      if (!nneg_ff) begin
         t_sat = (big_ff || quo_ff > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                      : $signed(quo_ff[31:0]);
      end else begin
         t_sat = (big_ff || quo_ff > 33'h0_8000_0000) ? 32'sh8000_0000
                                                      : 32'(-quo_ff);
      end

      mv_sh  = prod_ff >> FRACTION_BITS;
      mv_off = prod_neg_ff ? -$signed({2'b00, mv_sh}) : $signed({2'b00, mv_sh});
      mv_sum = 67'(start6[mv_prev]) + mv_off;
      priority if (mv_sum > 67'sh0_7FFF_FFFF)          mv_res = 32'sh7FFF_FFFF;
      else if (mv_sum < -67'sh0_8000_0000)             mv_res = 32'sh8000_0000;
      else                                              mv_res = mv_sum[31:0];
   end

   // Held particle A: cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_rad_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            held_st_ff[i] <= '0;
            held_en_ff[i] <= '0;
         end
      end else if (cmd.capture && !req_tuser) begin
         held_rad_ff <= in_rad;
         for (int i = 0; i < 3; i++) begin
            held_st_ff[i] <= in_st[i];
            held_en_ff[i] <= in_en[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_tuser) begin
         b_rad_ff <= in_rad;
         for (int i = 0; i < 3; i++) begin
            b_st_ff[i] <= in_st[i];
            b_en_ff[i] <= in_en[i];
         end
      end

      prod_ff     <= mul_a * mul_b;
      prod_neg_ff <= mul_neg;

      unique case (cmd.op)
         OP_DIFF: begin
            r_ff <= 32'(held_rad_ff) + 32'(b_rad_ff);
            for (int i = 0; i < 3; i++) begin
               c0_ff[i] <= 33'(b_st_ff[i]) - 33'(held_st_ff[i]);
               d_ff[i]  <= (34'(b_en_ff[i]) - 34'(held_en_ff[i]))
                           - (34'(b_st_ff[i]) - 34'(held_st_ff[i]));
            end
         end
         OP_NORM: begin
            rm_ff <= 30'(r_ff >> norm_k);
            for (int i = 0; i < 3; i++) begin
               cm_ff[i] <= 30'(c0_mag[i] >> norm_k);
               dm_ff[i] <= 30'(d_mag[i] >> norm_k);
               cs_ff[i] <= c0_ff[i][32];
               ds_ff[i] <= d_ff[i][33];
            end
            p_ff  <= '0;
            q_ff  <= '0;
            rr_ff <= '0;
            r2_ff <= '0;
         end
         OP_MUL: begin
            unique case (cmd.step)
               7'd1, 7'd2, 7'd3:  p_ff  <= p_ff + prod_s;
               7'd4, 7'd5, 7'd6:  q_ff  <= q_ff + prod_s;
               7'd7, 7'd8, 7'd9:  rr_ff <= rr_ff + prod_s;
               7'd10:             r2_ff <= prod_s;
               default: ;
            endcase
         end
         OP_PREP: diff_ff <= rr_ff - r2_ff;
         OP_WINIT: begin
            qa_ff <= {64'b0, q_ff[63] ? 64'(-q_ff) : 64'(q_ff)};
            qb_ff <= q_ff[63] ? 64'(-q_ff) : 64'(q_ff);
            ta_ff <= {64'b0, p_ff};
            tb_ff <= diff_ff[63] ? 64'(-diff_ff) : 64'(diff_ff);
            q2_ff <= '0;
            tt_ff <= '0;
         end
         OP_WIDE: begin
            if (qb_ff[0]) q2_ff <= q2_ff + qa_ff;
            if (tb_ff[0]) tt_ff <= tt_ff + ta_ff;
            qa_ff <= qa_ff << 1;
            ta_ff <= ta_ff << 1;
            qb_ff <= qb_ff >> 1;
            tb_ff <= tb_ff >> 1;
         end
         OP_JFORM: begin
            jsh_ff  <= j_val;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQRT: begin
            if (sq_remx >= sq_trial) begin
               rem_ff  <= sq_remx - sq_trial;
               root_ff <= {root_ff[62:0], 1'b1};
            end else begin
               rem_ff  <= sq_remx;
               root_ff <= {root_ff[62:0], 1'b0};
            end
            jsh_ff <= jsh_ff << 2;
         end
         OP_RANGE: begin
            num_ff  <= nm_mag[63:0];
            nneg_ff <= n_minus[65];
            drem_ff <= '0;
            quo_ff  <= '0;
            big_ff  <= 1'b0;
         end
         OP_DIV: begin
            drem_ff <= dv_ge ? 64'(dv_x - dv_den) : dv_x[63:0];
            quo_ff  <= {quo_ff[31:0], dv_ge};
            big_ff  <= big_ff | quo_ff[32];
            num_ff  <= num_ff << 1;
         end
         OP_TSAT: t_ff <= t_sat;
         OP_MOVE: begin
            if (cmd.step != '0) begin
               res_ff[mv_prev] <= mv_res;
            end
         end
         default: ;
      endcase

      if (cmd.out_load) begin
         hit_out_ff  <= cmd.out_hit;
         time_out_ff <= cmd.out_hit ? t_ff : '0;
         for (int i = 0; i < 6; i++) begin
            pos_out_ff[i] <= cmd.out_hit ? res_ff[i] : '0;
         end
      end
   end

   assign rsp_tuser = hit_out_ff;
   assign rsp_tdata = {pos_out_ff[5], pos_out_ff[4], pos_out_ff[3],
                       pos_out_ff[2], pos_out_ff[1], pos_out_ff[0], time_out_ff};

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import msct_pkg::*;

   typedef struct {
      bit                      slot;
      bit                      hold;
      logic [RADIUS_W-1:0]     rad;
      logic [2:0][COORD_W-1:0] st;
      logic [2:0][COORD_W-1:0] en;
   } sphere_req_type;

   typedef struct packed {
      logic                    hit;
      logic [2:0][COORD_W-1:0] b_pos;
      logic [2:0][COORD_W-1:0] a_pos;
      logic [COORD_W-1:0]      t;
   } contact_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   sphere_req_type pending[$];
   sphere_req_type cur;
   contact_type    contacts_due[$];
   int          errors = 0;
   int          hits_seen = 0;
   int          misses_seen = 0;
   int          requests_sent = 0;
   longint      cycle_count = 0;

   // Held copy of sphere A.
   logic [RADIUS_W-1:0] a_rad = '0;
   longint              a_st[3] = '{0, 0, 0};
   longint              a_en[3] = '{0, 0, 0};

   moving_sphere_collision_time dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic longint magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint shrink(longint v, int k);
      longint m;
      m = magn(v) >> k;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint move_to(longint s, longint e, longint t);
      longint delta, p;
      delta = e - s;
      p = (magn(delta) * magn(t)) >> FRACTION_BITS;
      if ((delta < 0) != (t < 0)) p = -p;
      return sat32(s + p);
   endfunction

   // Updates the held sphere A or computes the contact for sphere B.
   function automatic bit solve_contact(input sphere_req_type it, output contact_type res);
      longint r, mx, pp, qq, rr, diff, t;
      longint c0[3], d[3], bs[3], be[3];
      logic signed [127:0] wq, wp, wd, j, s, cand, np, nm, q;
      int k;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         bs[i] = longint'($signed(it.st[i]));
         be[i] = longint'($signed(it.en[i]));
      end
      if (!it.slot) begin
         a_rad = it.rad;
         for (int i = 0; i < 3; i++) begin
            a_st[i] = bs[i];
            a_en[i] = be[i];
         end
         return 0;
      end
      r = longint'(a_rad) + longint'(it.rad);
      mx = r;
      for (int i = 0; i < 3; i++) begin
         c0[i] = bs[i] - a_st[i];
         d[i] = (be[i] - a_en[i]) - c0[i];
         if (magn(c0[i]) > mx) mx = magn(c0[i]);
         if (magn(d[i]) > mx) mx = magn(d[i]);
      end
      k = 0;
      while ((mx >> k) >= (64'sd1 << 30)) k++;
      r = shrink(r, k);
      pp = 0; qq = 0; rr = 0;
      for (int i = 0; i < 3; i++) begin
         c0[i] = shrink(c0[i], k);
         d[i] = shrink(d[i], k);
         pp += d[i] * d[i];
         qq += c0[i] * d[i];
         rr += c0[i] * c0[i];
      end
      if (pp == 0) return 1;
      diff = rr - r * r;
      wq = 128'(qq); wp = 128'(pp); wd = 128'(diff);
      j = wq * wq - wp * wd;
      if (j < 0) return 1;
      s = 0;
      for (int b = 62; b >= 0; b--) begin
         cand = s | (128'sd1 <<< b);
         if (cand * cand <= j) s = cand;
      end
      np = -wq + s;
      nm = -wq - s;
      if ((np < 0 || np > wp) && (nm < 0 || nm > wp)) return 1;
      q = ((nm < 0 ? -nm : nm) <<< FRACTION_BITS) / wp;
      if (nm >= 0) t = q > 128'sd2147483647 ? 64'sd2147483647 : longint'(q);
      else t = q > 128'sd2147483648 ? -64'sd2147483648 : -longint'(q);
      res.hit = 1;
      res.t = t[31:0];
      for (int i = 0; i < 3; i++) begin
         res.a_pos[i] = 32'(move_to(a_st[i], a_en[i], t));
         res.b_pos[i] = 32'(move_to(bs[i], be[i], t));
      end
      return 1;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
   endtask

   task automatic add_req(bit slot, bit hold, longint rad, longint sx, longint sy,
                          longint sz, longint ex, longint ey, longint ez);
      sphere_req_type it;
      it.slot = slot;
      it.hold = hold;
      it.rad = rad[30:0];
      it.st = {sz[31:0], sy[31:0], sx[31:0]};
      it.en = {ez[31:0], ey[31:0], ex[31:0]};
      pending.push_back(it);
   endtask

   function automatic longint rnd_signed(int bits);
      longint v;
      if (bits >= 32) return longint'($signed($urandom));
      v = longint'($urandom) & ((64'sd1 << bits) - 1);
      return v - (64'sd1 << (bits - 1));
   endfunction

   // Idling is switched off over one long stretch of the run.
   function automatic bit quiet();
      return cycle_count > 60000 && cycle_count < 100000;
   endfunction

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      contact_type due;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            requests_sent++;
            if (solve_contact(cur, due)) contacts_due.push_back(due);
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 && (quiet() || $urandom_range(99) >= 27) &&
                !(pending[0].hold && contacts_due.size() > 0)) begin
               cur = pending.pop_front();
               req_tdata <= {1'b0, cur.en, cur.st, cur.rad};
               req_tuser <= cur.slot;
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      contact_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (contacts_due.size() == 0) begin
               report("unexpected response hit", {31'b0, rsp_tuser}, 32'b0);
            end else begin
               want = contacts_due.pop_front();
               if (want.hit) hits_seen++;
               else misses_seen++;
               if (got.hit !== want.hit) report("hit", {31'b0, got.hit}, {31'b0, want.hit});
               if (got.t !== want.t) report("contact_time", got.t, want.t);
               for (int i = 0; i < 3; i++) begin
                  if (got.a_pos[i] !== want.a_pos[i]) report("a_contact", got.a_pos[i],
                                                             want.a_pos[i]);
                  if (got.b_pos[i] !== want.b_pos[i]) report("b_contact", got.b_pos[i],
                                                             want.b_pos[i]);
               end
            end
         end
         rsp_tready <= quiet() || $urandom_range(99) >= 27;
      end
   end

   initial begin
      int bits, mode;
      longint one;
      one = 64'sd65536;
      // Sphere B right after reset uses the zeroed sphere A.
      add_req(1, 0, 0, 0, 0, 0, 0, 0, 0);
      // No relative motion.
      add_req(0, 0, one, 0, 0, 0, 0, 0, 0);
      add_req(1, 0, one, 5 * one, 0, 0, 5 * one, 0, 0);
      // Head-on pass through a resting sphere.
      add_req(0, 0, one, 0, 0, 0, 0, 0, 0);
      add_req(1, 0, one, 10 * one, 0, 0, -10 * one, 0, 0);
      // Already overlapping at the start: only the later root lies in the frame.
      add_req(0, 0, 2 * one, 0, 0, 0, 0, 0, 0);
      add_req(1, 0, 2 * one, one, 0, 0, 5 * one, 0, 0);
      // Repeated sphere B against the same A, missing sideways.
      add_req(1, 0, 0, 0, 3 * one, 0, one, 3 * one, 0);
      // Approaching but stopping short of contact.
      add_req(1, 0, one, 10 * one, 0, one, 5 * one, 0, one);
      // Extreme radius and coordinates.
      add_req(0, 0, 64'h7fffffff, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
              64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
      add_req(1, 0, 64'h7fffffff, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
              -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
      add_req(0, 0, 0, -64'sd2147483648, 64'sd2147483647, 0,
              64'sd2147483647, -64'sd2147483648, 0);
      add_req(1, 0, 0, 64'sd2147483647, -64'sd2147483648, 0,
              -64'sd2147483648, 64'sd2147483647, 0);
      // Tiny spheres crossing exactly.
      add_req(0, 1, 1, -4, 0, 0, 4, 0, 0);
      add_req(1, 0, 1, 4, 0, 0, -4, 0, 0);
      add_req(1, 0, 64'h7fffffff, 0, 0, 0, 0, 0, 0);
      while (pending.size() < 1650) begin
         mode = $urandom_range(9);
         bits = mode == 0 ? 32 : $urandom_range(3, 31);
         if (mode != 1)
            add_req(0, $urandom_range(199) == 0,
                    mode == 0 ? $urandom : $urandom & ((32'd1 << (bits - 1)) - 1),
                    rnd_signed(bits), rnd_signed(bits), rnd_signed(bits),
                    rnd_signed(bits), rnd_signed(bits), rnd_signed(bits));
         add_req(1, 0, mode == 0 ? $urandom : $urandom & ((32'd1 << (bits - 1)) - 1),
                 rnd_signed(bits), rnd_signed(bits), rnd_signed(bits),
                 rnd_signed(bits), rnd_signed(bits), rnd_signed(bits));
      end
      repeat (12) @(posedge clock);
      reset <= 0;
      while (pending.size() > 0 || req_tvalid) @(posedge clock);
      while (contacts_due.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d requests; checked %0d contacts and %0d misses",
               requests_sent, hits_seen, misses_seen);
      $display("covered extreme coordinates, overlap at start, zero motion and random scales");
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #60ms;
      $display("timeout with %0d contacts outstanding", contacts_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
